[design/assert_macros.svh]
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/uart8n1_pkg.sv]
`default_nettype none

package uart8n1_pkg;

  // request codes carried in the kind field
  localparam logic [1:0] KindTick = 2'd0;
  localparam logic [1:0] KindSend = 2'd1;
  localparam logic [1:0] KindRecv = 2'd2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgCyclesPerBit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRxTimeout    = 2'd1;
  localparam int unsigned CfgDataW = 32;

  // register reset values
  localparam logic [15:0] CyclesPerBitRst = 16'd6076;
  localparam logic [31:0] RxTimeoutRst    = 32'd700000;

  // start, eight data bits, stop
  localparam logic [3:0] FrameBits = 4'd10;
  localparam logic [3:0] DataBits  = 4'd8;

  // receiver phases
  typedef enum logic [3:0] {
    RxIdle = 4'b0001,
    RxWait = 4'b0010,
    RxData = 4'b0100,
    RxStop = 4'b1000
  } rx_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       rx_line;
  } in_beat_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       rx_busy;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic       rx_timeout;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] cycles_per_bit;
    logic [31:0] rx_timeout_cycles;
  } cfg_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       timeout;
  } rx_res_t;

endpackage

`default_nettype wire

[design/uart8n1_tx.sv]
`default_nettype none

module uart8n1_tx (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [1:0]             kind_i,
  input  wire logic [7:0]             tx_byte_i,
  input  wire logic [15:0]            cycles_per_bit_i,
  output uart8n1_pkg::tx_res_t        res_o
);

  logic [8:0]  shift_q, shift_d, shift_cur;
  logic [3:0]  bits_q, bits_d, bits_cur;
  logic [15:0] tick_q, tick_d, tick_cur, tick_inc;
  logic        load;

  // frame load, line level and bit timing for one tick
  always_comb begin
    load      = (kind_i == uart8n1_pkg::KindSend) && (bits_q == 4'd0);
    shift_cur = load ? {1'b1, tx_byte_i} : shift_q;
    bits_cur  = load ? uart8n1_pkg::FrameBits : bits_q;
    tick_cur  = load ? 16'd0 : tick_q;
    tick_inc  = tick_cur + 16'd1;
    shift_d   = shift_cur;
    bits_d    = bits_cur;
    tick_d    = tick_cur;
    res_o     = '0;
    if (bits_cur == 4'd0) begin
      res_o.line = 1'b1;
      res_o.busy = 1'b0;
    end else begin
      res_o.line = (bits_cur == uart8n1_pkg::FrameBits) ? 1'b0 : shift_cur[0];
      res_o.busy = 1'b1;
      tick_d     = tick_inc;
      if (tick_inc >= cycles_per_bit_i) begin
        tick_d = 16'd0;
        if (bits_cur < uart8n1_pkg::FrameBits) begin
          shift_d = {1'b1, shift_cur[8:1]};
        end
        bits_d = bits_cur - 4'd1;
      end
    end
  end

  // state advances once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '1;
      bits_q  <= '0;
      tick_q  <= '0;
    end else if (step_i) begin
      shift_q <= shift_d;
      bits_q  <= bits_d;
      tick_q  <= tick_d;
    end
  end

endmodule

`default_nettype wire

[design/uart8n1_rx.sv]
`default_nettype none

module uart8n1_rx (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [1:0]             kind_i,
  input  wire logic                   rx_line_i,
  input  wire uart8n1_pkg::cfg_t      cfg_i,
  output uart8n1_pkg::rx_res_t        res_o
);

  uart8n1_pkg::rx_phase_e phase_q, phase_d, phase_cur;
  logic [15:0] tick_q, tick_d, tick_inc, limit;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d, shift_nx;
  logic [31:0] wait_q, wait_d, wait_cur;
  logic        done, tout;

  // start-bit wait with timeout, mid-bit sampling and stop-bit hold
  always_comb begin
    tick_inc = tick_q + 16'd1;
    limit    = (bit_q == 4'd0) ? {1'b0, cfg_i.cycles_per_bit[15:1]} : cfg_i.cycles_per_bit;
    shift_nx = {rx_line_i, shift_q[7:1]};
    if ((kind_i == uart8n1_pkg::KindRecv) && (phase_q == uart8n1_pkg::RxIdle)) begin
      phase_cur = uart8n1_pkg::RxWait;
      wait_cur  = 32'd0;
    end else begin
      phase_cur = phase_q;
      wait_cur  = wait_q;
    end
    phase_d = phase_cur;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_cur;
    done    = 1'b0;
    tout    = 1'b0;
    case (phase_cur)
      uart8n1_pkg::RxIdle: begin
      end
      uart8n1_pkg::RxWait: begin
        if (!rx_line_i) begin
          phase_d = uart8n1_pkg::RxData;
          tick_d  = 16'd0;
          bit_d   = 4'd0;
        end else if (wait_cur >= cfg_i.rx_timeout_cycles) begin
          phase_d = uart8n1_pkg::RxIdle;
          tout    = 1'b1;
        end else begin
          wait_d = wait_cur + 32'd1;
        end
      end
      uart8n1_pkg::RxData: begin
        tick_d = tick_inc;
        if (tick_inc >= limit) begin
          tick_d = 16'd0;
          if (bit_q == 4'd0) begin
            bit_d = 4'd1;
          end else begin
            shift_d = shift_nx;
            if (bit_q >= uart8n1_pkg::DataBits) begin
              done    = 1'b1;
              bit_d   = 4'd0;
              phase_d = uart8n1_pkg::RxStop;
            end else begin
              bit_d = bit_q + 4'd1;
            end
          end
        end
      end
      uart8n1_pkg::RxStop: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.cycles_per_bit) begin
          tick_d  = 16'd0;
          phase_d = uart8n1_pkg::RxIdle;
        end
      end
      default: begin
        phase_d = uart8n1_pkg::RxIdle;
      end
    endcase
    res_o.busy    = (phase_d != uart8n1_pkg::RxIdle);
    res_o.done    = done;
    res_o.rx_byte = done ? shift_nx : 8'd0;
    res_o.timeout = tout;
  end

  // state advances once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uart8n1_pkg::RxIdle;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
    end
  end

endmodule

`default_nettype wire

[design/uart_tx_rx_8n1_top.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | in_data_i   (kind, tx_byte, rx_line)
// out     | output    | out_valid_o/out_ready_i | out_data_o (tx/rx status, rx_byte)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one beat in, one beat out; a beat is held in the input register and its result is
// registered in the output register when the beat is processed
// sustained rate is one beat per cycle while the output is not stalled
// a stalled output holds the result; the input register still takes one more beat
// reset loads the register defaults and an idle transmitter and receiver
// config writes are always ready and take effect on the next edge
`default_nettype none
`include "assert_macros.svh"

module uart_tx_rx_8n1_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire uart8n1_pkg::in_beat_t                in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output uart8n1_pkg::out_beat_t                    out_data_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [uart8n1_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [uart8n1_pkg::CfgDataW-1:0]     cfg_data_i
);

  uart8n1_pkg::in_beat_t  in_q;
  uart8n1_pkg::out_beat_t out_q, out_d;
  uart8n1_pkg::cfg_t      cfg_q;
  uart8n1_pkg::tx_res_t   tx_res;
  uart8n1_pkg::rx_res_t   rx_res;
  logic                   in_vld_q, out_vld_q, step;
  logic                   chk_done, chk_tout, chk_idle;

  // beat is processed when the result register is free or draining
  assign step        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycles_per_bit    <= uart8n1_pkg::CyclesPerBitRst;
      cfg_q.rx_timeout_cycles <= uart8n1_pkg::RxTimeoutRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        uart8n1_pkg::CfgCyclesPerBit: cfg_q.cycles_per_bit <= cfg_data_i[15:0];
        uart8n1_pkg::CfgRxTimeout:    cfg_q.rx_timeout_cycles <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  uart8n1_tx u_tx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .kind_i           (in_q.kind),
    .tx_byte_i        (in_q.tx_byte),
    .cycles_per_bit_i (cfg_q.cycles_per_bit),
    .res_o            (tx_res)
  );

  uart8n1_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .kind_i    (in_q.kind),
    .rx_line_i (in_q.rx_line),
    .cfg_i     (cfg_q),
    .res_o     (rx_res)
  );

  // result assembly
  always_comb begin
    out_d.tx_line    = tx_res.line;
    out_d.tx_busy    = tx_res.busy;
    out_d.rx_busy    = rx_res.busy;
    out_d.rx_done    = rx_res.done;
    out_d.rx_byte    = rx_res.rx_byte;
    out_d.rx_timeout = rx_res.timeout;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  // result flags seen by the checks
  assign chk_done = out_vld_q && out_q.rx_done;
  assign chk_tout = out_vld_q && out_q.rx_timeout;
  assign chk_idle = out_vld_q && !out_q.tx_busy;

  // checks
  `ASSERT_ALWAYS(a_done_tout_excl, clk_i, rst_ni, !(chk_done && chk_tout), "rx done with timeout")
  `ASSERT_IMPLY(a_done_busy, clk_i, rst_ni, chk_done, out_q.rx_busy, "done without stop hold")
  `ASSERT_IMPLY(a_tx_idle_high, clk_i, rst_ni, chk_idle, out_q.tx_line, "tx low while idle")
  `ASSERT_NEXT(a_step_out, clk_i, rst_ni, step, out_vld_q, "processed beat lost")

endmodule

`default_nettype wire
